@@ hdl/modinv_pkg.sv @@
package modinv_pkg;

    // Default operand width and configuration constants.
    localparam int WIDTH_DEFAULT = 31;
    localparam int MODULUS_RESET = 2;
    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] REG_MODULUS_ADDR = 2'd0;

    // Program step addresses.
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_TEST   = 3'd1;
    localparam step_t STEP_UP     = 3'd2;
    localparam step_t STEP_SUB    = 3'd3;
    localparam step_t STEP_SWAP   = 3'd4;
    localparam step_t STEP_FINISH = 3'd5;

    // Datapath operations selected by a control word.
    typedef logic [2:0] op_t;
    localparam op_t OP_NONE   = 3'd0;
    localparam op_t OP_LOAD   = 3'd1;
    localparam op_t OP_SETUP  = 3'd2;
    localparam op_t OP_UP     = 3'd3;
    localparam op_t OP_SUB    = 3'd4;
    localparam op_t OP_SWAP   = 3'd5;
    localparam op_t OP_RESULT = 3'd6;

    // Jump conditions selected by a control word.
    typedef logic [2:0] cond_t;
    localparam cond_t COND_NEVER    = 3'd0;
    localparam cond_t COND_ALWAYS   = 3'd1;
    localparam cond_t COND_IN_ACC   = 3'd2;
    localparam cond_t COND_R1_ZERO  = 3'd3;
    localparam cond_t COND_CAN_UP   = 3'd4;
    localparam cond_t COND_K_NZ     = 3'd5;
    localparam cond_t COND_OUT_FREE = 3'd6;

    // One microcode word: on a true condition the sequencer jumps to target,
    // otherwise it holds the step or falls through to the next one.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } ctrl_word_t;

    // Microcode program for the extended Euclidean algorithm.
    function automatic ctrl_word_t program_rom(input step_t step);
        ctrl_word_t cw;
        case (step)
            STEP_IDLE:   cw = '{op: OP_LOAD,   cond: COND_IN_ACC,   hold: 1'b1,
                                target: STEP_TEST};
            STEP_TEST:   cw = '{op: OP_SETUP,  cond: COND_R1_ZERO,  hold: 1'b0,
                                target: STEP_FINISH};
            STEP_UP:     cw = '{op: OP_UP,     cond: COND_CAN_UP,   hold: 1'b0,
                                target: STEP_UP};
            STEP_SUB:    cw = '{op: OP_SUB,    cond: COND_K_NZ,     hold: 1'b0,
                                target: STEP_SUB};
            STEP_SWAP:   cw = '{op: OP_SWAP,   cond: COND_ALWAYS,   hold: 1'b0,
                                target: STEP_TEST};
            STEP_FINISH: cw = '{op: OP_RESULT, cond: COND_OUT_FREE, hold: 1'b1,
                                target: STEP_IDLE};
            default:     cw = '{op: OP_NONE,   cond: COND_ALWAYS,   hold: 1'b0,
                                target: STEP_IDLE};
        endcase
        return cw;
    endfunction

endpackage

@@ hdl/modular_inverse.sv @@
// Modular inverse by the extended Euclidean algorithm. Each request carries a
// residue "value"; the block returns "inverse", the Bezout coefficient of value
// with respect to the modulus register, with the modulus added once if it came
// out negative (value 0 gives 0; for a value not coprime to the modulus the
// result satisfies value*inverse == gcd mod modulus). One request is worked on
// at a time. A small microcode program steps a shift-and-subtract divider:
// each quotient step aligns the divisor under the remainder, subtracts it back
// down one quotient bit at a time, then rotates the remainder and coefficient
// pairs; a request is loaded first and the result written last. The modulus
// is written through the APB port at address 0 and must only change while no
// request is in flight; the result register lets a new request start while
// the previous result still waits to be taken.
module modular_inverse #(
    parameter int WIDTH = modinv_pkg::WIDTH_DEFAULT,
    localparam int PDATA_W = (WIDTH > 32) ? 64 : 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [modinv_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]                  pwdata,
    output logic [PDATA_W-1:0]                  prdata,
    output logic                                pready,
    // Request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [WIDTH-1:0]                    value,
    // Result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [WIDTH-1:0]                    inverse
);

    localparam int SW = WIDTH + 2;
    localparam int KW = $clog2(WIDTH);

    modinv_pkg::ctrl_word_t cw;
    modinv_pkg::step_t      step_reg;
    modinv_pkg::step_t      step_next;

    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] r0_reg;
    logic [WIDTH-1:0] r1_reg;
    logic [SW-1:0]    s0_reg;
    logic [SW-1:0]    s1_reg;
    logic [WIDTH-1:0] d_reg;
    logic [SW-1:0]    acc_reg;
    logic [KW-1:0]    k_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] inverse_reg;

    logic             in_acc;
    logic             out_free;
    logic             can_up;
    logic             sub_ge;
    logic             k_nz;
    logic             cond_true;
    logic [SW-1:0]    fixed_coef;

    // Configuration register access.
    assign pready = 1'b1;
    assign prdata = (paddr == modinv_pkg::REG_MODULUS_ADDR) ? PDATA_W'(modulus_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= WIDTH'(modinv_pkg::MODULUS_RESET);
        end
        else if (psel && penable && pwrite && pready
                 && paddr == modinv_pkg::REG_MODULUS_ADDR)
        begin
            modulus_reg <= pwdata[WIDTH-1:0];
        end
    end

    // Handshake status and datapath conditions.
    assign in_stall   = (step_reg != modinv_pkg::STEP_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign can_up     = {d_reg, 1'b0} <= {1'b0, r0_reg};
    assign sub_ge     = d_reg <= r0_reg;
    assign k_nz       = (k_reg != '0);
    assign fixed_coef = s0_reg[SW-1] ? (s0_reg + {2'b00, modulus_reg}) : s0_reg;

    // Sequencer: fetch the control word and pick the next step.
    assign cw = modinv_pkg::program_rom(step_reg);

    always_comb
    begin
        case (cw.cond)
            modinv_pkg::COND_NEVER:    cond_true = 1'b0;
            modinv_pkg::COND_ALWAYS:   cond_true = 1'b1;
            modinv_pkg::COND_IN_ACC:   cond_true = in_acc;
            modinv_pkg::COND_R1_ZERO:  cond_true = (r1_reg == '0);
            modinv_pkg::COND_CAN_UP:   cond_true = can_up;
            modinv_pkg::COND_K_NZ:     cond_true = k_nz;
            modinv_pkg::COND_OUT_FREE: cond_true = out_free;
            default:                   cond_true = 1'b0;
        endcase

        if (cond_true)
        begin
            step_next = cw.target;
        end
        else if (cw.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= modinv_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Euclid datapath. The divider aligns the divisor d under the remainder,
    // then subtracts it back down one quotient bit a cycle while acc collects
    // quotient times s1 in Horner order.
    always_ff @(posedge clk)
    begin
        case (cw.op)
            modinv_pkg::OP_LOAD:
            begin
                if (in_acc)
                begin
                    r0_reg <= value;
                    r1_reg <= modulus_reg;
                    s0_reg <= SW'(1);
                    s1_reg <= '0;
                end
            end
            modinv_pkg::OP_SETUP:
            begin
                d_reg   <= r1_reg;
                acc_reg <= '0;
                k_reg   <= '0;
            end
            modinv_pkg::OP_UP:
            begin
                if (can_up)
                begin
                    d_reg <= {d_reg[WIDTH-2:0], 1'b0};
                    k_reg <= k_reg + 1'b1;
                end
            end
            modinv_pkg::OP_SUB:
            begin
                if (sub_ge)
                begin
                    r0_reg <= r0_reg - d_reg;
                end
                acc_reg <= {acc_reg[SW-2:0], 1'b0} + (sub_ge ? s1_reg : '0);
                if (k_nz)
                begin
                    d_reg <= {1'b0, d_reg[WIDTH-1:1]};
                    k_reg <= k_reg - 1'b1;
                end
            end
            modinv_pkg::OP_SWAP:
            begin
                // r0 now holds the remainder; rotate the pairs.
                r0_reg <= r1_reg;
                r1_reg <= r0_reg;
                s0_reg <= s1_reg;
                s1_reg <= s0_reg - acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cw.op == modinv_pkg::OP_RESULT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.op == modinv_pkg::OP_RESULT && out_free)
        begin
            inverse_reg <= fixed_coef[WIDTH-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign inverse   = inverse_reg;

    // A new result only appears after the program reaches its finishing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_reg == modinv_pkg::STEP_FINISH))
        else $error("result appeared outside the finishing step");

    // The divider never runs with a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == modinv_pkg::STEP_UP || step_reg == modinv_pkg::STEP_SUB)
        |-> (d_reg != '0))
        else $error("divider running with zero divisor");

    // A taken result is dropped unless a fresh one is written the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && step_reg != modinv_pkg::STEP_FINISH)
        |=> !out_valid_reg)
        else $error("result repeated after being taken");

    // A request is taken only at the idle step, and the program then moves to its test step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (step_reg == modinv_pkg::STEP_TEST))
        else $error("request accepted but program did not start");

endmodule
